[design/stbs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stbs_pkg
// Shared constants, register codes and types of the edge-triggered timebase
// sweep.
// ----------------------------------------------------------------------------
package stbs_pkg;

	// Geometry of the sweep and the plot area
	localparam int SWEEP_START = 20;
	localparam int SWEEP_WIDTH = 280;
	localparam int PLOT_TOP    = 40;
	localparam int PLOT_HEIGHT = 200;

	// Fixed properties of the display and converters
	localparam int FULL_SCALE_BITS = 12;
	localparam int FULL_SCALE      = 4096;
	localparam int MIN_PERIOD_COLS = 10;
	localparam int MAX_STEP        = 16;
	localparam int MEAS_GAP        = 10;
	localparam int MEAS_MARGIN     = 20;

	localparam int HALF        = PLOT_HEIGHT / 2;
	localparam int TARGET      = SWEEP_WIDTH / 5;
	localparam int TARGET_LO   = TARGET / 2;
	localparam int TARGET_HI   = TARGET * 2;
	localparam int REF_BASE    = PLOT_TOP + HALF;
	localparam int MEAS_BASE   = PLOT_TOP + HALF + MEAS_GAP;
	localparam int MEAS_SPAN   = HALF - MEAS_MARGIN;
	localparam int SWEEP_LIMIT = SWEEP_START + SWEEP_WIDTH;

	localparam int SAMPLE_W = 12;
	localparam int COL_W    = 10;
	localparam int ROW_W    = 10;
	localparam int STEP_W   = 5;
	localparam int COUNT_W  = 16;
	localparam int REG_IDX_W = 2;

	localparam logic [COL_W-1:0]    START_COL       = COL_W'(SWEEP_START);
	localparam logic [SAMPLE_W-1:0] CENTER_RESET    = 12'd2048;
	localparam logic [SAMPLE_W-1:0] THRESHOLD_RESET = 12'd100;
	localparam logic [SAMPLE_W-1:0] PREV_REF_RESET  = 12'd2048;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_CENTER_LEVEL   = 2'd0,
		REG_EDGE_THRESHOLD = 2'd1,
		REG_TRACE_READY    = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [COL_W-1:0]   column;
		logic               wrapped;
		logic [STEP_W-1:0]  step_now;
		logic [COUNT_W-1:0] period_count;
		logic               period_new;
	} trig_res_t;

endpackage

[design/stbs_sample_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stbs_sample_if
// Input channel: one reference and one measured sample per beat.
// ----------------------------------------------------------------------------
interface stbs_sample_if;
	import stbs_pkg::*;

	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] ref_sample;
	logic [SAMPLE_W-1:0] meas_sample;

	modport source (output valid, output ref_sample, output meas_sample, input ready);
	modport sink (input valid, input ref_sample, input meas_sample, output ready);
endinterface

[design/stbs_result_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stbs_result_if
// Output channel: one plot point with sweep status per beat.
// ----------------------------------------------------------------------------
interface stbs_result_if;
	import stbs_pkg::*;

	logic               valid;
	logic               ready;
	logic [COL_W-1:0]   column;
	logic [ROW_W-1:0]   ref_row;
	logic [ROW_W-1:0]   meas_row;
	logic               connect;
	logic               wrapped;
	logic [STEP_W-1:0]  step_now;
	logic [COUNT_W-1:0] period_count;
	logic               period_new;

	modport source (
		output valid, output column, output ref_row, output meas_row, output connect,
		output wrapped, output step_now, output period_count, output period_new,
		input ready
	);
	modport sink (
		input valid, input column, input ref_row, input meas_row, input connect,
		input wrapped, input step_now, input period_count, input period_new,
		output ready
	);
endinterface

[design/stbs_cfg_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stbs_cfg_if
// Register write channel: register index and write data per beat.
// ----------------------------------------------------------------------------
interface stbs_cfg_if;
	import stbs_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [REG_IDX_W-1:0] index;
	logic [SAMPLE_W-1:0]  data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

[design/scope_edge_timebase_sweep_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scope_edge_timebase_sweep_unit
// An accepted sample beat is presented as its result beat in the next cycle.
// Throughput: one beat per cycle; the result register is the only stage.
// The sample channel stalls only while a result is held and not taken.
// Reset (arst_n low) clears sweep state to the start column, step 1, and
// restores the registers to centre 2048, threshold 100, trace ready set.
// ----------------------------------------------------------------------------
module scope_edge_timebase_sweep_unit (
	input  logic  clk,
	input  logic  arst_n,
	stbs_sample_if.sink   smp,
	stbs_cfg_if.sink      cfg,
	stbs_result_if.source res
);
	import stbs_pkg::*;

	// Configuration registers
	logic [SAMPLE_W-1:0] center_level_q;
	logic [SAMPLE_W-1:0] edge_threshold_q;
	logic                trace_ready_q;

	// Result register
	logic               res_valid_q;
	logic [COL_W-1:0]   column_q;
	logic [ROW_W-1:0]   ref_row_q, meas_row_q;
	logic               connect_q, wrapped_q, period_new_q;
	logic [STEP_W-1:0]  step_now_q;
	logic [COUNT_W-1:0] period_count_q;

	logic      accept;
	trig_res_t trig;
	logic [ROW_W-1:0] ref_row, meas_row;
	logic      connect;

	// Take a new beat whenever the result register is empty or being drained
	assign smp.ready = !res_valid_q || res.ready;
	assign accept    = smp.valid && smp.ready;
	assign cfg.ready = 1'b1;

	// Register writes; indexes beyond the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_level_q   <= CENTER_RESET;
			edge_threshold_q <= THRESHOLD_RESET;
			trace_ready_q    <= 1'b1;
		end else if (cfg.valid) begin
			case (reg_idx_t'(cfg.index))
				REG_CENTER_LEVEL:   center_level_q   <= cfg.data;
				REG_EDGE_THRESHOLD: edge_threshold_q <= cfg.data;
				REG_TRACE_READY:    trace_ready_q    <= cfg.data[0];
				default: ;
			endcase
		end
	end

	// Edge tracking and sweep advance
	stbs_trigger u_trigger (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (accept),
		.ref_sample     (smp.ref_sample),
		.center_level   (center_level_q),
		.edge_threshold (edge_threshold_q),
		.res            (trig)
	);

	// Sample to row mapping
	stbs_rowmap u_rowmap (
		.ref_sample  (smp.ref_sample),
		.meas_sample (smp.meas_sample),
		.ref_row     (ref_row),
		.meas_row    (meas_row)
	);

	// Draw a connecting line only past the first column of the sweep and only while trace ready is set
	assign connect = trace_ready_q && (trig.column > START_COL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (smp.ready) begin
			res_valid_q <= smp.valid;
		end
	end

	// Hold the payload until it is taken; load on every accepted beat
	always_ff @(posedge clk) begin
		if (accept) begin
			column_q       <= trig.column;
			ref_row_q      <= ref_row;
			meas_row_q     <= meas_row;
			connect_q      <= connect;
			wrapped_q      <= trig.wrapped;
			step_now_q     <= trig.step_now;
			period_count_q <= trig.period_count;
			period_new_q   <= trig.period_new;
		end
	end

	assign res.valid        = res_valid_q;
	assign res.column       = column_q;
	assign res.ref_row      = ref_row_q;
	assign res.meas_row     = meas_row_q;
	assign res.connect      = connect_q;
	assign res.wrapped      = wrapped_q;
	assign res.step_now     = step_now_q;
	assign res.period_count = period_count_q;
	assign res.period_new   = period_new_q;
endmodule

[design/stbs_rowmap.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stbs_rowmap
// Map the two samples to screen rows: reference in the upper half,
// measured in the lower half.
// ----------------------------------------------------------------------------
module stbs_rowmap (
	input  logic [stbs_pkg::SAMPLE_W-1:0] ref_sample,
	input  logic [stbs_pkg::SAMPLE_W-1:0] meas_sample,
	output logic [stbs_pkg::ROW_W-1:0]    ref_row,
	output logic [stbs_pkg::ROW_W-1:0]    meas_row
);
	import stbs_pkg::*;

	localparam int PROD_W = 22;
	localparam int SUM_W  = 12;

	logic [SAMPLE_W:0]   meas_inv;
	logic [PROD_W-1:0]   ref_prod;
	logic [PROD_W-1:0]   meas_prod;
	logic [SUM_W-1:0]    ref_sum;
	logic [SUM_W-1:0]    meas_sum;

	// Scale by a constant and drop the full-scale bits
	assign meas_inv  = (SAMPLE_W+1)'(FULL_SCALE) - {1'b0, meas_sample};
	assign ref_prod  = PROD_W'(ref_sample) * PROD_W'(HALF);
	assign meas_prod = PROD_W'(meas_inv) * PROD_W'(MEAS_SPAN);

	assign ref_sum  = SUM_W'(REF_BASE) - SUM_W'(ref_prod >> FULL_SCALE_BITS);
	assign meas_sum = SUM_W'(MEAS_BASE) + SUM_W'(meas_prod >> FULL_SCALE_BITS);

	assign ref_row  = ref_sum[ROW_W-1:0];
	assign meas_row = meas_sum[ROW_W-1:0];
endmodule

[design/stbs_trigger.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stbs_trigger
// Rising-edge detection, period measurement, timebase step control and
// sweep column advance with wrap.
// ----------------------------------------------------------------------------
module stbs_trigger (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  logic [stbs_pkg::SAMPLE_W-1:0] ref_sample,
	input  logic [stbs_pkg::SAMPLE_W-1:0] center_level,
	input  logic [stbs_pkg::SAMPLE_W-1:0] edge_threshold,
	output stbs_pkg::trig_res_t           res
);
	import stbs_pkg::*;

	localparam int NEXT_W = 12;

	logic [COL_W-1:0]    sweep_col_q, edge_col_q;
	logic [SAMPLE_W-1:0] prev_ref_q;
	logic                armed_q;
	logic [COUNT_W-1:0]  since_edge_q, period_meas_q;
	logic [STEP_W-1:0]   col_step_q;

	logic [SAMPLE_W:0]   ref_sum;
	logic                edge_hit;
	logic [COL_W-1:0]    width;
	logic                width_ok;
	logic [STEP_W-1:0]   step_d;
	logic                armed_d;
	logic [COL_W-1:0]    edge_col_d, sweep_col_d;
	logic [COUNT_W-1:0]  since_edge_d, period_meas_d;
	logic                meas_new;
	logic [NEXT_W-1:0]   next_col, limit;
	logic                do_wrap;

	assign ref_sum  = {1'b0, prev_ref_q} + {1'b0, edge_threshold};
	assign edge_hit = ({1'b0, ref_sample} > ref_sum) && (prev_ref_q < center_level);
	assign width    = sweep_col_q - edge_col_q;
	assign width_ok = width > COL_W'(MIN_PERIOD_COLS);

	always_comb begin
		armed_d       = armed_q;
		edge_col_d    = edge_col_q;
		period_meas_d = period_meas_q;
		step_d        = col_step_q;
		meas_new      = 1'b0;
		since_edge_d  = since_edge_q + COUNT_W'(1);
		if (edge_hit) begin
			since_edge_d = COUNT_W'(1);
			edge_col_d   = sweep_col_q;
			if (!armed_q) begin
				armed_d       = 1'b1;
				period_meas_d = '0;
			end else if (width_ok) begin
				period_meas_d = since_edge_q;
				meas_new      = 1'b1;
				if (NEXT_W'(width) < NEXT_W'(TARGET_LO)) begin
					if (col_step_q > STEP_W'(1)) step_d = col_step_q - STEP_W'(1);
				end else if (NEXT_W'(width) > NEXT_W'(TARGET_HI)) begin
					if (col_step_q < STEP_W'(MAX_STEP)) step_d = col_step_q + STEP_W'(1);
				end
			end
		end

		// Advance the sweep; wrap clears the edge tracking
		next_col    = NEXT_W'(sweep_col_q) + NEXT_W'(step_d);
		limit       = NEXT_W'(SWEEP_LIMIT) - NEXT_W'(step_d);
		do_wrap     = (next_col >= limit) || (next_col > NEXT_W'((1 << COL_W) - 1));
		sweep_col_d = next_col[COL_W-1:0];
		if (do_wrap) begin
			sweep_col_d   = START_COL;
			armed_d       = 1'b0;
			period_meas_d = '0;
			since_edge_d  = '0;
		end
	end

	always_comb begin
		res.column       = sweep_col_q;
		res.wrapped      = do_wrap;
		res.step_now     = step_d;
		res.period_count = period_meas_d;
		res.period_new   = meas_new;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_col_q   <= START_COL;
			prev_ref_q    <= PREV_REF_RESET;
			armed_q       <= 1'b0;
			edge_col_q    <= '0;
			since_edge_q  <= '0;
			period_meas_q <= '0;
			col_step_q    <= STEP_W'(1);
		end else if (accept) begin
			sweep_col_q   <= sweep_col_d;
			prev_ref_q    <= ref_sample;
			armed_q       <= armed_d;
			edge_col_q    <= edge_col_d;
			since_edge_q  <= since_edge_d;
			period_meas_q <= period_meas_d;
			col_step_q    <= step_d;
		end
	end
endmodule

[tb/sv/tb_scope_edge_timebase_sweep_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_scope_edge_timebase_sweep_unit
// Self-checking bench for the edge-triggered timebase sweep. Sample pairs go
// in, one plot point per beat comes out. A software copy of the trigger,
// timebase and plot logic predicts every point, and each result beat is
// compared with the oldest prediction. The run starts with a directed
// sequence, then random waveform bursts under several register settings.
// Valid and ready are toggled in random bursts.
// ----------------------------------------------------------------------------
module tb_scope_edge_timebase_sweep_unit;
	import stbs_pkg::*;

	localparam int RUN_LIMIT = 400000;
	localparam int COL_MAX = (1 << COL_W) - 1;
	localparam logic [REG_IDX_W-1:0] REG_SPARE = 2'd3;

	// Directed opening: edge at the threshold and one above it, previous
	// sample at the centre level, first edge arming, short and measured
	// periods, and the extremes of both samples.
	localparam logic [SAMPLE_W-1:0] DIR_REF [25] = '{
		12'd0, 12'd4095, 12'd2048, 12'd4095, 12'd0, 12'd100, 12'd0, 12'd101,
		12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0,
		12'd0, 12'd0, 12'd4095, 12'd2047, 12'd3000, 12'd0, 12'd4095
	};
	localparam logic [SAMPLE_W-1:0] DIR_MEAS [25] = '{
		12'd0, 12'd4095, 12'd0, 12'd4095, 12'd2048, 12'd1, 12'd4094, 12'd2047,
		12'd2049, 12'd0, 12'd4095, 12'd1365, 12'd2730, 12'd0, 12'd4095, 12'd7,
		12'd4088, 12'd0, 12'd4095, 12'd512, 12'd3584, 12'd0, 12'd4095, 12'd4095,
		12'd0
	};

	typedef struct packed {
		logic [COL_W-1:0]   column;
		logic [ROW_W-1:0]   ref_row;
		logic [ROW_W-1:0]   meas_row;
		logic               connect;
		logic               wrapped;
		logic [STEP_W-1:0]  step_now;
		logic [COUNT_W-1:0] period_count;
		logic               period_new;
	} plot_point_t;

	// Trigger and plot predictor with its own register copy, plus the queue
	// of plot points still owed by the block.
	class trace_point_checker;
		logic [SAMPLE_W-1:0] centre_lvl;
		logic [SAMPLE_W-1:0] rise_thr;
		logic                trace_on;
		logic [COL_W-1:0]    sweep_col;
		logic [COL_W-1:0]    edge_col;
		logic [SAMPLE_W-1:0] last_ref;
		logic                tracking;
		logic [COUNT_W-1:0]  since_edge;
		logic [COUNT_W-1:0]  period_len;
		logic [STEP_W-1:0]   col_step;
		plot_point_t         owed_points[$];
		int                  fails;

		function new();
			fails = 0;
			centre_lvl = CENTER_RESET;
			rise_thr = THRESHOLD_RESET;
			trace_on = 1'b1;
			sweep_col = START_COL;
			edge_col = '0;
			last_ref = PREV_REF_RESET;
			tracking = 1'b0;
			since_edge = '0;
			period_len = '0;
			col_step = STEP_W'(1);
		endfunction

		function void write_reg(logic [REG_IDX_W-1:0] idx, logic [SAMPLE_W-1:0] data);
			case (idx)
				REG_CENTER_LEVEL: begin
					centre_lvl = data;
				end
				REG_EDGE_THRESHOLD: begin
					rise_thr = data;
				end
				REG_TRACE_READY: begin
					trace_on = data[0];
				end
				default: begin
				end
			endcase
		endfunction

		function void note_sample(logic [SAMPLE_W-1:0] ref_smp, logic [SAMPLE_W-1:0] meas_smp);
			logic [COL_W-1:0] col;
			logic [COL_W-1:0] span;
			int nxt;
			int lim;
			plot_point_t p;
			col = sweep_col;
			p = '0;
			p.column = col;
			// trigger first, then the timebase nudge
			if (int'(ref_smp) > int'(last_ref) + int'(rise_thr) && last_ref < centre_lvl) begin
				if (!tracking) begin
					tracking = 1'b1;
					edge_col = col;
					period_len = '0;
				end else begin
					span = col - edge_col;
					if (span > MIN_PERIOD_COLS) begin
						period_len = since_edge;
						p.period_new = 1'b1;
						if (span < TARGET_LO) begin
							if (col_step > 1) col_step--;
						end else if (span > TARGET_HI) begin
							if (col_step < MAX_STEP) col_step++;
						end
					end
					edge_col = col;
				end
				since_edge = '0;
			end
			last_ref = ref_smp;
			since_edge++;
			p.ref_row = ROW_W'(REF_BASE - (int'(ref_smp) * HALF) / FULL_SCALE);
			p.meas_row = ROW_W'(MEAS_BASE + ((FULL_SCALE - int'(meas_smp)) * MEAS_SPAN) / FULL_SCALE);
			p.connect = trace_on && (col > SWEEP_START);
			// advance the sweep; a wrap drops the edge tracking
			nxt = int'(col) + int'(col_step);
			lim = SWEEP_LIMIT - int'(col_step);
			if (nxt >= lim || nxt > COL_MAX) begin
				sweep_col = START_COL;
				tracking = 1'b0;
				period_len = '0;
				since_edge = '0;
				p.wrapped = 1'b1;
			end else begin
				sweep_col = COL_W'(nxt);
			end
			p.step_now = col_step;
			p.period_count = period_len;
			owed_points.push_back(p);
		endfunction

		function int outstanding();
			return owed_points.size();
		endfunction

		function void report(string what);
			$display("mismatch @%0t: %s", $realtime, what);
			fails++;
		endfunction

		function void cmp(string field, int got, int want);
			if (got != want) report($sformatf("%s got %0d want %0d", field, got, want));
		endfunction

		function void check_point(plot_point_t got);
			plot_point_t want;
			if (owed_points.size() == 0) begin
				report("result beat with nothing owed");
				return;
			end
			want = owed_points.pop_front();
			cmp("column", got.column, want.column);
			cmp("ref_row", got.ref_row, want.ref_row);
			cmp("meas_row", got.meas_row, want.meas_row);
			cmp("connect", got.connect, want.connect);
			cmp("wrapped", got.wrapped, want.wrapped);
			cmp("step_now", got.step_now, want.step_now);
			cmp("period_count", got.period_count, want.period_count);
			cmp("period_new", got.period_new, want.period_new);
		endfunction
	endclass

	logic clk;
	logic arst_n;

	stbs_sample_if smp();
	stbs_cfg_if    cfg();
	stbs_result_if res();

	scope_edge_timebase_sweep_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.smp    (smp),
		.cfg    (cfg),
		.res    (res)
	);

	trace_point_checker board = new();

	// Idling switches and the register values the stimulus aims at
	bit gap_on;
	bit stall_on;
	int stall_left;
	int cycles;
	int centre_cfg;
	int thr_cfg;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycles++;
		if (cycles > RUN_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// Result side: stall in random bursts while stalling is enabled
	always @(negedge clk) begin
		if (stall_left != 0) begin
			stall_left--;
			res.ready <= 1'b0;
		end else if (stall_on && $urandom_range(0, 4) == 0) begin
			stall_left = $urandom_range(0, 6);
			res.ready <= 1'b0;
		end else begin
			res.ready <= 1'b1;
		end
	end

	// Check every result beat against the oldest owed point
	always @(posedge clk) begin
		if (arst_n && res.valid && res.ready)
			board.check_point({res.column, res.ref_row, res.meas_row, res.connect,
				res.wrapped, res.step_now, res.period_count, res.period_new});
	end

	// Present one sample beat, hold it until taken, then note it. Valid stays
	// high on exit so that back-to-back beats never drop it.
	task automatic send_sample(logic [SAMPLE_W-1:0] ref_smp, logic [SAMPLE_W-1:0] meas_smp);
		if (gap_on && $urandom_range(0, 3) == 0) begin
			smp.valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(negedge clk);
		end
		smp.valid <= 1'b1;
		smp.ref_sample <= ref_smp;
		smp.meas_sample <= meas_smp;
		do @(posedge clk); while (!smp.ready);
		board.note_sample(ref_smp, meas_smp);
		@(negedge clk);
	endtask

	// Drop valid and wait until every owed point has come back
	task automatic drain_samples();
		smp.valid <= 1'b0;
		do @(negedge clk); while (board.outstanding() != 0);
	endtask

	task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [SAMPLE_W-1:0] data);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= data;
		do @(posedge clk); while (!cfg.ready);
		board.write_reg(idx, data);
		@(negedge clk);
	endtask

	// Write all three registers; junk in the upper bits of the trace flag
	task automatic set_regs(int centre, int thr, bit trace);
		centre_cfg = centre;
		thr_cfg = thr;
		write_reg(REG_CENTER_LEVEL, SAMPLE_W'(centre));
		write_reg(REG_EDGE_THRESHOLD, SAMPLE_W'(thr));
		write_reg(REG_TRACE_READY, SAMPLE_W'(($urandom_range(0, 4095) & 'hFFE) | trace));
	endtask

	// Mostly square waves whose rising step is meant to clear the trigger at the current
	// settings, with random periods so the timebase wanders both ways; the
	// rest is noise. Optionally pause until drained partway through.
	task automatic run_random(int n_items, int pause_at, bit quiet);
		int done;
		int period;
		int burst;
		int lo;
		int hi;
		int k;
		done = 0;
		while (done < n_items) begin
			if (quiet) begin
				gap_on = 1'b0;
				stall_on = 1'b0;
			end else begin
				gap_on = $urandom_range(0, 2) != 0;
				stall_on = $urandom_range(0, 2) != 0;
			end
			if ($urandom_range(0, 4) == 0) begin
				period = 2;
				burst = $urandom_range(1, 20);
				lo = 0;
				hi = 0;
			end else begin
				period = $urandom_range(4, 160);
				burst = period * $urandom_range(2, 5);
				lo = (centre_cfg == 0) ? 0 : $urandom_range(0, centre_cfg - 1);
				hi = lo + thr_cfg + 1 + $urandom_range(0, 400);
				if (hi > 4095) hi = 4095;
			end
			for (k = 0; k < burst && done < n_items; k++) begin
				if (hi == 0)
					send_sample(SAMPLE_W'($urandom_range(0, 4095)),
						SAMPLE_W'($urandom_range(0, 4095)));
				else
					send_sample(SAMPLE_W'(((k % period) < period / 2) ? lo : hi),
						SAMPLE_W'($urandom_range(0, 4095)));
				done++;
				if (done == pause_at) drain_samples();
			end
		end
	endtask

	initial begin
		int ph;
		int i;
		smp.valid = 1'b0;
		smp.ref_sample = '0;
		smp.meas_sample = '0;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
		res.ready = 1'b0;
		gap_on = 1'b0;
		stall_on = 1'b0;
		stall_left = 0;
		cycles = 0;
		centre_cfg = CENTER_RESET;
		thr_cfg = THRESHOLD_RESET;
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed opening on the reset register values
		stall_on = 1'b1;
		for (i = 0; i < 25; i++) begin
			gap_on = 1'($urandom_range(0, 1));
			send_sample(DIR_REF[i], DIR_MEAS[i]);
		end

		for (ph = 1; ph <= 6; ph++) begin
			drain_samples();
			case (ph)
				1: begin
					set_regs(2048, 100, 1'b1);
					// an unused index must be ignored
					write_reg(REG_SPARE, SAMPLE_W'($urandom_range(0, 4095)));
				end
				2: set_regs(4095, 0, 1'b0);
				3: set_regs(0, $urandom_range(0, 4095), 1'b1);
				4: set_regs($urandom_range(1, 4095), 4095, 1'b1);
				5: set_regs($urandom_range(1024, 4095), $urandom_range(0, 800),
					1'($urandom_range(0, 1)));
				default: set_regs(2048, 100, 1'b1);
			endcase
			cfg.valid <= 1'b0;
			case (ph)
				1: run_random(300, 0, 1'b0);
				2: run_random(250, 0, 1'b0);
				3: run_random(120, 0, 1'b0);
				4: run_random(120, 0, 1'b0);
				5: run_random(450, 200, 1'b0);
				default: run_random(450, 0, 1'b1);
			endcase
		end

		// Let the last results drain, then settle
		drain_samples();
		repeat (4) @(posedge clk);
		if (board.outstanding() != 0) board.report("points still owed at the end");
		if (board.fails == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

[files.f]
design/stbs_pkg.sv
design/stbs_sample_if.sv
design/stbs_result_if.sv
design/stbs_cfg_if.sv
design/stbs_rowmap.sv
design/stbs_trigger.sv
design/scope_edge_timebase_sweep_unit.sv
tb/sv/tb_scope_edge_timebase_sweep_unit.sv
